// File: sv/twm_pkg.sv
// twm_pkg: shared types and constants for the two-wire write master
// no dependencies
`default_nettype none

package twm_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned STRETCH_W = 8;
  localparam logic [STRETCH_W-1:0] STRETCH_RESET = 8'd20;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [8:0] {
    PH_IDLE        = 9'b0_0000_0001,
    PH_START_A     = 9'b0_0000_0010,
    PH_START_B     = 9'b0_0000_0100,
    PH_STOP_A      = 9'b0_0000_1000,
    PH_STOP_B      = 9'b0_0001_0000,
    PH_BIT_HIGH    = 9'b0_0010_0000,
    PH_BIT_STRETCH = 9'b0_0100_0000,
    PH_ACK_LOW     = 9'b0_1000_0000,
    PH_ACK_STRETCH = 9'b1_0000_0000
  } phase_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic done_res;
  } res_t;

endpackage

`default_nettype wire

// File: sv/twm_seq.sv
// twm_seq: phase sequencer, shift register and stretch counter
// depends on twm_pkg
`default_nettype none

module twm_seq #(
  parameter int unsigned BITS_PER_WORD = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire logic [1:0]                        op,
  input  wire logic [twm_pkg::DATA_W-1:0]        data_byte,
  input  wire logic                              scl_sense,
  input  wire logic [twm_pkg::STRETCH_W-1:0]     stretch_limit,
  output twm_pkg::res_t                          res_nxt
);
  import twm_pkg::*;

  localparam int unsigned BL_W = $clog2(BITS_PER_WORD + 1);

  phase_t               phase_r, phase_nxt;
  logic [DATA_W-1:0]    shift_r, shift_nxt;
  logic [BL_W-1:0]      bits_left_r, bits_left_nxt;
  logic [STRETCH_W-1:0] stretch_cnt_r, stretch_cnt_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 done;

  logic [STRETCH_W-1:0] cnt_base;
  logic                 keep_wait;
  logic [BL_W-1:0]      bl_dec;
  logic [DATA_W-1:0]    shift_dn;
  logic                 is_stretch;

  always_comb begin
    is_stretch = (phase_r == PH_BIT_STRETCH) || (phase_r == PH_ACK_STRETCH);
    cnt_base   = is_stretch ? stretch_cnt_r : '0;
    keep_wait  = !scl_sense && (cnt_base < stretch_limit);
    bl_dec     = (bits_left_r != '0) ? bits_left_r - 1'b1 : '0;
    shift_dn   = shift_r >> 1;
  end

  always_comb begin
    phase_nxt       = phase_r;
    shift_nxt       = shift_r;
    bits_left_nxt   = bits_left_r;
    stretch_cnt_nxt = stretch_cnt_r;
    scl_nxt         = scl_r;
    sda_nxt         = sda_r;
    done            = 1'b0;
    if (phase_r == PH_IDLE) begin
      case (op)
        OP_START: begin
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b1;
          phase_nxt = PH_START_A;
        end
        OP_STOP: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_STOP_A;
        end
        OP_WRITE: begin
          shift_nxt     = data_byte;
          bits_left_nxt = BL_W'(BITS_PER_WORD);
          scl_nxt       = 1'b1;
          sda_nxt       = data_byte[0];
          phase_nxt     = PH_BIT_HIGH;
        end
        default: begin
        end
      endcase
    end else if (op == OP_TICK) begin
      case (phase_r)
        PH_START_A: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_START_B;
        end
        PH_START_B: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        PH_STOP_A: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_STOP_B;
        end
        PH_STOP_B: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        PH_BIT_HIGH, PH_BIT_STRETCH: begin
          if (phase_r == PH_BIT_HIGH) begin
            stretch_cnt_nxt = '0;
          end
          if (keep_wait) begin
            stretch_cnt_nxt = cnt_base + 1'b1;
            phase_nxt       = PH_BIT_STRETCH;
          end else begin
            bits_left_nxt = bl_dec;
            if (bl_dec == '0) begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
              phase_nxt = PH_ACK_LOW;
            end else begin
              shift_nxt = shift_dn;
              scl_nxt   = 1'b1;
              sda_nxt   = shift_dn[0];
              phase_nxt = PH_BIT_HIGH;
            end
          end
        end
        PH_ACK_LOW, PH_ACK_STRETCH: begin
          if (phase_r == PH_ACK_LOW) begin
            scl_nxt         = 1'b1;
            stretch_cnt_nxt = '0;
          end
          if (keep_wait) begin
            stretch_cnt_nxt = cnt_base + 1'b1;
            phase_nxt       = PH_ACK_STRETCH;
          end else begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      shift_r       <= '0;
      bits_left_r   <= '0;
      stretch_cnt_r <= '0;
      scl_r         <= 1'b0;
      sda_r         <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      shift_r       <= shift_nxt;
      bits_left_r   <= bits_left_nxt;
      stretch_cnt_r <= stretch_cnt_nxt;
      scl_r         <= scl_nxt;
      sda_r         <= sda_nxt;
    end
  end

  always_comb begin
    res_nxt.scl_level = scl_nxt;
    res_nxt.sda_level = sda_nxt;
    res_nxt.busy_res  = (phase_nxt != PH_IDLE);
    res_nxt.done_res  = done;
  end

endmodule

`default_nettype wire

// File: sv/twm_out.sv
// twm_out: result register stage with valid and stall
// depends on twm_pkg
`default_nettype none

module twm_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire twm_pkg::res_t res_in,
  input  wire logic          out_stall,
  output logic               out_valid,
  output twm_pkg::res_t      res_out,
  output logic               busy_hold
);
  import twm_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = out_valid_r;
  assign res_out   = res_r;
  // stage full and downstream stalled
  assign busy_hold = out_valid_r && out_stall;

endmodule

`default_nettype wire

// File: sv/two_wire_write_master.sv
// two_wire_write_master: write-only two-wire master, LSB first, with clock stretch wait
// result of a transaction is registered and is on the out_ ports in the cycle after it is accepted
// throughput: one transaction per cycle while in_stall is low, set by the single result register
// reset (rst_n low, synchronous): phase idle, both drives low, stretch_limit 20
// depends on twm_pkg, twm_seq, twm_out
`default_nettype none

module two_wire_write_master #(
  parameter int unsigned BITS_PER_WORD = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_op,
  input  wire logic [twm_pkg::DATA_W-1:0]     in_data_byte,
  input  wire logic                           in_scl_sense,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_scl_level,
  output logic                                out_sda_level,
  output logic                                out_busy_res,
  output logic                                out_done_res,
  input  wire logic                           cfg_we,
  input  wire logic [twm_pkg::STRETCH_W-1:0]  cfg_wdata
);
  import twm_pkg::*;

  logic [STRETCH_W-1:0] stretch_limit_r;
  logic                 accept;
  logic                 busy_hold;
  res_t                 res_nxt;
  res_t                 res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stretch_limit_r <= STRETCH_RESET;
    end else if (cfg_we) begin
      stretch_limit_r <= cfg_wdata;
    end
  end

  assign in_stall = busy_hold;
  assign accept   = in_valid && !busy_hold;

  twm_seq #(
    .BITS_PER_WORD(BITS_PER_WORD)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .op            (in_op),
    .data_byte     (in_data_byte),
    .scl_sense     (in_scl_sense),
    .stretch_limit (stretch_limit_r),
    .res_nxt       (res_nxt)
  );

  twm_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_in    (res_nxt),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_q),
    .busy_hold (busy_hold)
  );

  assign out_scl_level = res_q.scl_level;
  assign out_sda_level = res_q.sda_level;
  assign out_busy_res  = res_q.busy_res;
  assign out_done_res  = res_q.done_res;

endmodule

`default_nettype wire
